// File: rtl/sfd_pkg.sv
// Shared types and constants for the STOMP frame deframer.
// Holds the parser phase type, the result tag codes and the header key table.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package sfd_pkg;

  localparam int unsigned BODY_LEN_W   = 31;
  localparam int unsigned LEN_KEY_SIZE = 14;
  localparam int unsigned KEY_POS_W    = 4;

  typedef enum logic [2:0] {
    PH_CMD      = 3'd0,
    PH_HDR      = 3'd1,
    PH_BODY_NUL = 3'd2,
    PH_BODY_CNT = 3'd3,
    PH_TRAIL    = 3'd4
  } phase_t;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_CMD   = 3'd1;
  localparam logic [2:0] KIND_KEY   = 3'd2;
  localparam logic [2:0] KIND_VALUE = 3'd3;
  localparam logic [2:0] KIND_BODY  = 3'd4;

  localparam logic [2:0] MARK_NONE     = 3'd0;
  localparam logic [2:0] MARK_CMD_END  = 3'd1;
  localparam logic [2:0] MARK_PAIR_END = 3'd2;
  localparam logic [2:0] MARK_DISCARD  = 3'd3;
  localparam logic [2:0] MARK_HDR_END  = 3'd4;
  localparam logic [2:0] MARK_FRM_END  = 3'd5;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_BAD_LEN = 2'd1;
  localparam logic [1:0] ERR_NO_NUL  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  localparam logic [KEY_POS_W-1:0] KEY_FULL = KEY_POS_W'(LEN_KEY_SIZE);

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_CR) || (c == CH_FF);
  endfunction

  // Characters of the "content-length" header key.
  function automatic logic [7:0] len_key(input logic [KEY_POS_W-1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      4'd0:    ch = 8'h63; // c
      4'd1:    ch = 8'h6F; // o
      4'd2:    ch = 8'h6E; // n
      4'd3:    ch = 8'h74; // t
      4'd4:    ch = 8'h65; // e
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h74; // t
      4'd7:    ch = 8'h2D; // -
      4'd8:    ch = 8'h6C; // l
      4'd9:    ch = 8'h65; // e
      4'd10:   ch = 8'h6E; // n
      4'd11:   ch = 8'h67; // g
      4'd12:   ch = 8'h74; // t
      4'd13:   ch = 8'h68; // h
      default: ch = CH_NUL;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

// File: rtl/stomp_frame_deframer.sv
// STOMP frame deframer top level: tags each received byte of a STOMP stream.
// Depends on sfd_pkg for the phase type, tag codes and header key table.
`timescale 1ns / 1ps
`default_nettype none

// Takes one received byte per transfer and returns one tagged copy of it per
// transfer: command, header key, header value or body, plus end marks for
// the command line, each header pair, colonless lines, the end of headers and
// the end of the frame. Blank lines and leading whitespace before a command
// are skipped. The last exact "content-length" header, if its decimal value is
// nonzero, selects a counted body that must be followed by a NUL; otherwise the
// body ends at the first NUL. A bad length value drops the frame. Throughput
// is one byte per cycle while out_stall is low. Each byte goes through the input
// register, then a single pass of parser logic (the length accumulator's
// shift-and-add times ten is the deepest path), into the result register. A
// second byte is taken into the input register while a result waits.
// LENGTH_BITS (16 to 31) sets the widest accepted content length.
module stomp_frame_deframer #(
  parameter int unsigned LENGTH_BITS = 31
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [7:0]                     in_rx_byte,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [7:0]                          out_data_byte,
  output logic [2:0]                          out_byte_kind,
  output logic [2:0]                          out_end_mark,
  output logic [1:0]                          out_error_code,
  output logic [sfd_pkg::BODY_LEN_W-1:0]      out_body_length
);

  import sfd_pkg::*;

  localparam int unsigned PROD_W = LENGTH_BITS + 4;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;

  // Parser state.
  phase_t                 phase_r, phase_nxt;
  logic [KEY_POS_W-1:0]   key_pos_r, key_pos_nxt;
  logic                   key_match_r, key_match_nxt;
  logic                   seen_sep_r, seen_sep_nxt;
  logic                   line_empty_r, line_empty_nxt;
  logic                   cmd_started_r, cmd_started_nxt;
  logic [LENGTH_BITS-1:0] len_accum_r, len_accum_nxt;
  logic                   len_bad_r, len_bad_nxt;
  logic [LENGTH_BITS-1:0] body_rem_r, body_rem_nxt;

  // Result register.
  logic                   out_valid_r;
  logic [7:0]             out_byte_r;
  logic [2:0]             out_kind_r;
  logic [2:0]             out_mark_r;
  logic [1:0]             out_err_r;
  logic [LENGTH_BITS-1:0] out_blen_r;

  logic                   advance;
  logic                   in_xfer;
  logic [7:0]             c;
  logic [2:0]             kind;
  logic [2:0]             mark;
  logic [1:0]             err;
  logic [LENGTH_BITS-1:0] blen;
  logic                   is_digit;
  logic                   key_ok;
  logic [PROD_W-1:0]      len_times_ten;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_xfer  = in_valid && !in_stall;
  assign c        = s1_byte_r;
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

  // Accumulator times ten plus the digit, as shifts and adds.
  assign len_times_ten = (PROD_W'(len_accum_r) << 3) + (PROD_W'(len_accum_r) << 1)
                       + PROD_W'(c[3:0]);

  always_comb begin
    phase_nxt       = phase_r;
    key_pos_nxt     = key_pos_r;
    key_match_nxt   = key_match_r;
    seen_sep_nxt    = seen_sep_r;
    line_empty_nxt  = line_empty_r;
    cmd_started_nxt = cmd_started_r;
    len_accum_nxt   = len_accum_r;
    len_bad_nxt     = len_bad_r;
    body_rem_nxt    = body_rem_r;
    kind            = KIND_NONE;
    mark            = MARK_NONE;
    err             = ERR_NONE;
    blen            = '0;
    key_ok          = key_match_r && (key_pos_r == KEY_FULL);

    unique case (phase_r)
      PH_HDR: begin
        if (!seen_sep_r) begin
          if (c == CH_LF) begin
            if (line_empty_r) begin
              mark = MARK_HDR_END;
              if (len_bad_r) begin
                err             = ERR_BAD_LEN;
                phase_nxt       = PH_CMD;
                cmd_started_nxt = 1'b0;
                len_accum_nxt   = '0;
                len_bad_nxt     = 1'b0;
                body_rem_nxt    = '0;
              end else begin
                blen = len_accum_r;
                if (len_accum_r != '0) begin
                  body_rem_nxt = len_accum_r;
                  phase_nxt    = PH_BODY_CNT;
                end else begin
                  phase_nxt = PH_BODY_NUL;
                end
              end
            end else begin
              mark = MARK_DISCARD;
            end
            key_pos_nxt    = '0;
            key_match_nxt  = 1'b1;
            seen_sep_nxt   = 1'b0;
            line_empty_nxt = 1'b1;
          end else if (c == CH_COLON) begin
            line_empty_nxt = 1'b0;
            seen_sep_nxt   = 1'b1;
            key_match_nxt  = key_ok;
            key_pos_nxt    = '0;
            // A fresh content-length header replaces any earlier value.
            if (key_ok) begin
              len_accum_nxt = '0;
              len_bad_nxt   = 1'b0;
            end
          end else begin
            kind           = KIND_KEY;
            line_empty_nxt = 1'b0;
            if (key_match_r && (key_pos_r < KEY_FULL) && (c == len_key(key_pos_r))) begin
              key_pos_nxt = key_pos_r + 1'b1;
            end else begin
              key_match_nxt = 1'b0;
            end
          end
        end else begin
          if (c == CH_LF) begin
            mark = MARK_PAIR_END;
            // An empty content-length value is bad.
            if (key_match_r && (key_pos_r == '0)) begin
              len_bad_nxt = 1'b1;
            end
            key_pos_nxt    = '0;
            key_match_nxt  = 1'b1;
            seen_sep_nxt   = 1'b0;
            line_empty_nxt = 1'b1;
          end else begin
            kind = KIND_VALUE;
            if (key_match_r && !len_bad_r) begin
              if (is_digit) begin
                key_pos_nxt = KEY_POS_W'(1);
                if (len_times_ten[PROD_W-1:LENGTH_BITS] != '0) begin
                  len_bad_nxt = 1'b1;
                end else begin
                  len_accum_nxt = len_times_ten[LENGTH_BITS-1:0];
                end
              end else begin
                len_bad_nxt = 1'b1;
              end
            end
          end
        end
      end
      PH_BODY_NUL: begin
        if (c == CH_NUL) begin
          mark            = MARK_FRM_END;
          phase_nxt       = PH_CMD;
          key_pos_nxt     = '0;
          key_match_nxt   = 1'b1;
          seen_sep_nxt    = 1'b0;
          line_empty_nxt  = 1'b1;
          cmd_started_nxt = 1'b0;
          len_accum_nxt   = '0;
          len_bad_nxt     = 1'b0;
          body_rem_nxt    = '0;
        end else begin
          kind = KIND_BODY;
        end
      end
      PH_BODY_CNT: begin
        kind = KIND_BODY;
        if (body_rem_r <= LENGTH_BITS'(1)) begin
          body_rem_nxt = '0;
          phase_nxt    = PH_TRAIL;
        end else begin
          body_rem_nxt = body_rem_r - 1'b1;
        end
      end
      PH_TRAIL: begin
        mark = MARK_FRM_END;
        if (c != CH_NUL) begin
          err = ERR_NO_NUL;
        end
        phase_nxt       = PH_CMD;
        key_pos_nxt     = '0;
        key_match_nxt   = 1'b1;
        seen_sep_nxt    = 1'b0;
        line_empty_nxt  = 1'b1;
        cmd_started_nxt = 1'b0;
        len_accum_nxt   = '0;
        len_bad_nxt     = 1'b0;
        body_rem_nxt    = '0;
      end
      PH_CMD: begin
        if (cmd_started_r) begin
          if (c == CH_LF) begin
            mark            = MARK_CMD_END;
            phase_nxt       = PH_HDR;
            cmd_started_nxt = 1'b0;
            key_pos_nxt     = '0;
            key_match_nxt   = 1'b1;
            seen_sep_nxt    = 1'b0;
            line_empty_nxt  = 1'b1;
          end else begin
            kind = KIND_CMD;
          end
        end else if (!is_space(c)) begin
          cmd_started_nxt = 1'b1;
          kind            = KIND_CMD;
        end
      end
      default: begin
        // Unused phase codes fall back to waiting for a command line.
        phase_nxt = PH_CMD;
        if (!is_space(c)) begin
          cmd_started_nxt = 1'b1;
          kind            = KIND_CMD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      phase_r       <= PH_CMD;
      key_pos_r     <= '0;
      key_match_r   <= 1'b1;
      seen_sep_r    <= 1'b0;
      line_empty_r  <= 1'b1;
      cmd_started_r <= 1'b0;
      len_accum_r   <= '0;
      len_bad_r     <= 1'b0;
      body_rem_r    <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        phase_r       <= phase_nxt;
        key_pos_r     <= key_pos_nxt;
        key_match_r   <= key_match_nxt;
        seen_sep_r    <= seen_sep_nxt;
        line_empty_r  <= line_empty_nxt;
        cmd_started_r <= cmd_started_nxt;
        len_accum_r   <= len_accum_nxt;
        len_bad_r     <= len_bad_nxt;
        body_rem_r    <= body_rem_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_rx_byte;
    end
    if (advance) begin
      out_byte_r <= c;
      out_kind_r <= kind;
      out_mark_r <= mark;
      out_err_r  <= err;
      out_blen_r <= blen;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_data_byte   = out_byte_r;
  assign out_byte_kind   = out_kind_r;
  assign out_end_mark    = out_mark_r;
  assign out_error_code  = out_err_r;
  assign out_body_length = BODY_LEN_W'(out_blen_r);

endmodule

`default_nettype wire

// File: rtl/sfd_checker.sv
// Port-level checker for the STOMP frame deframer, bound to its top level.
// Depends on sfd_pkg for the tag codes.
`timescale 1ns / 1ps
`default_nettype none

module sfd_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [7:0]                     out_data_byte,
  input wire logic [2:0]                     out_byte_kind,
  input wire logic [2:0]                     out_end_mark,
  input wire logic [1:0]                     out_error_code,
  input wire logic [sfd_pkg::BODY_LEN_W-1:0] out_body_length
);

  import sfd_pkg::*;

  // The input side only stalls behind a result that is itself stalled.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a waiting result");

  // A tagged content byte never also carries an end mark.
  a_kind_no_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_byte_kind != KIND_NONE) |-> out_end_mark == MARK_NONE)
    else $error("content byte carries an end mark");

  // Errors only appear on the headers-end or frame-end transfer.
  a_err_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != ERR_NONE) |->
      ((out_error_code == ERR_BAD_LEN) && (out_end_mark == MARK_HDR_END)) ||
      ((out_error_code == ERR_NO_NUL) && (out_end_mark == MARK_FRM_END)))
    else $error("error code on the wrong transfer");

  // A nonzero length is reported only with a clean end of headers.
  a_len_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_body_length != '0) |->
      (out_end_mark == MARK_HDR_END) && (out_error_code == ERR_NONE))
    else $error("body length outside a clean end of headers");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte) &&
      $stable(out_byte_kind) && $stable(out_end_mark))
    else $error("stalled result changed");

endmodule

bind stomp_frame_deframer sfd_checker u_sfd_checker (.*);

`default_nettype wire

// File: sim/sfd_tag_checker.sv
// Result checker for the STOMP frame deframer testbench.
// Predicts the tag of every accepted byte and compares each result transfer in order.
// Depends on sfd_pkg for the phase type, tag codes and character constants.
`timescale 1ns / 1ps

module sfd_tag_checker #(
  parameter int unsigned LENGTH_BITS = 31
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [7:0]                     out_data_byte,
  input  logic [2:0]                     out_byte_kind,
  input  logic [2:0]                     out_end_mark,
  input  logic [1:0]                     out_error_code,
  input  logic [sfd_pkg::BODY_LEN_W-1:0] out_body_length,
  output int                             fail_count,
  output int                             waiting_count
);

  import sfd_pkg::*;

  typedef struct packed {
    logic [7:0]            data;
    logic [2:0]            kind;
    logic [2:0]            mark;
    logic [1:0]            err;
    logic [BODY_LEN_W-1:0] blen;
  } tag_t;

  localparam logic [8*LEN_KEY_SIZE-1:0] LEN_KEY = "content-length";
  localparam longint unsigned LEN_MAX = (64'd1 << LENGTH_BITS) - 64'd1;

  phase_t          ph;
  int unsigned     key_pos;
  bit              key_ok;
  bit              got_colon;
  bit              line_blank;
  bit              cmd_on;
  bit              len_bad;
  longint unsigned len_acc;
  longint unsigned body_left;

  tag_t expected_tags[$];
  int   errors = 0;

  function automatic void fresh_line();
    key_pos    = 0;
    key_ok     = 1'b1;
    got_colon  = 1'b0;
    line_blank = 1'b1;
  endfunction

  function automatic void fresh_frame();
    ph = PH_CMD;
    fresh_line();
    cmd_on    = 1'b0;
    len_acc   = 0;
    len_bad   = 1'b0;
    body_left = 0;
  endfunction

  function automatic bit blank_char(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR || c == CH_FF;
  endfunction

  function automatic tag_t predict_tag(input logic [7:0] c);
    tag_t            t;
    longint unsigned v;
    t      = '0;
    t.data = c;
    case (ph)
      PH_HDR: begin
        if (!got_colon) begin
          if (c == CH_LF) begin
            if (line_blank) begin
              t.mark = MARK_HDR_END;
              if (len_bad) begin
                t.err = ERR_BAD_LEN;
                fresh_frame();
              end else begin
                t.blen = len_acc[BODY_LEN_W-1:0];
                if (len_acc != 0) begin
                  body_left = len_acc;
                  ph = PH_BODY_CNT;
                end else begin
                  ph = PH_BODY_NUL;
                end
              end
            end else begin
              t.mark = MARK_DISCARD;
              fresh_line();
            end
          end else if (c == CH_COLON) begin
            line_blank = 1'b0;
            got_colon  = 1'b1;
            key_ok     = key_ok && key_pos == LEN_KEY_SIZE;
            key_pos    = 0;
            // A new exact content-length key restarts the value it carries.
            if (key_ok) begin
              len_acc = 0;
              len_bad = 1'b0;
            end
          end else begin
            t.kind     = KIND_KEY;
            line_blank = 1'b0;
            if (key_ok && key_pos < LEN_KEY_SIZE &&
                c == LEN_KEY[8*(LEN_KEY_SIZE-1-key_pos) +: 8])
              key_pos++;
            else
              key_ok = 1'b0;
          end
        end else begin
          if (c == CH_LF) begin
            t.mark = MARK_PAIR_END;
            // No digit seen in a content-length value means it was empty.
            if (key_ok && key_pos == 0)
              len_bad = 1'b1;
            fresh_line();
          end else begin
            t.kind = KIND_VALUE;
            if (key_ok && !len_bad) begin
              if (c >= CH_ZERO && c <= CH_NINE) begin
                v = len_acc * 10 + (c - CH_ZERO);
                key_pos = 1;
                if (v > LEN_MAX)
                  len_bad = 1'b1;
                else
                  len_acc = v;
              end else begin
                len_bad = 1'b1;
              end
            end
          end
        end
      end
      PH_BODY_NUL: begin
        if (c == CH_NUL) begin
          t.mark = MARK_FRM_END;
          fresh_frame();
        end else begin
          t.kind = KIND_BODY;
        end
      end
      PH_BODY_CNT: begin
        t.kind = KIND_BODY;
        if (body_left <= 1) begin
          body_left = 0;
          ph = PH_TRAIL;
        end else begin
          body_left--;
        end
      end
      PH_TRAIL: begin
        t.mark = MARK_FRM_END;
        if (c != CH_NUL)
          t.err = ERR_NO_NUL;
        fresh_frame();
      end
      default: begin
        if (cmd_on && ph == PH_CMD) begin
          if (c == CH_LF) begin
            t.mark = MARK_CMD_END;
            ph     = PH_HDR;
            cmd_on = 1'b0;
            fresh_line();
          end else begin
            t.kind = KIND_CMD;
          end
        end else if (!blank_char(c)) begin
          ph     = PH_CMD;
          cmd_on = 1'b1;
          t.kind = KIND_CMD;
        end else begin
          ph = PH_CMD;
        end
      end
    endcase
    return t;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    tag_t want;
    if (!rst_n) begin
      fresh_frame();
      expected_tags.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_tags.size() == 0) begin
          errors++;
          $display("%0t: result transfer with none expected, actual byte %0h",
                   $time, out_data_byte);
        end else begin
          want = expected_tags.pop_front();
          check_field("data_byte", 32'(want.data), 32'(out_data_byte));
          check_field("byte_kind", 32'(want.kind), 32'(out_byte_kind));
          check_field("end_mark", 32'(want.mark), 32'(out_end_mark));
          check_field("error_code", 32'(want.err), 32'(out_error_code));
          check_field("body_length", 32'(want.blen), 32'(out_body_length));
        end
      end
      if (in_valid && !in_stall)
        expected_tags.insert(expected_tags.size(), predict_tag(in_rx_byte));
    end
    fail_count    <= errors;
    waiting_count <= expected_tags.size();
  end

endmodule

// File: sim/tb.sv
// Testbench top for the STOMP frame deframer: clock, reset and byte stimulus.
// Sends directed and random STOMP streams with random idling on both sides.
// Depends on sfd_pkg, stomp_frame_deframer and sfd_tag_checker.
`timescale 1ns / 1ps

module tb;
  import sfd_pkg::*;

  localparam int unsigned LENGTH_BITS = 31;
  localparam int unsigned RANDOM_BYTES = 1200;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_rx_byte = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [7:0]            out_data_byte;
  logic [2:0]            out_byte_kind;
  logic [2:0]            out_end_mark;
  logic [1:0]            out_error_code;
  logic [BODY_LEN_W-1:0] out_body_length;
  int                    fail_count;
  int                    waiting_count;

  logic [7:0]  stream[$];
  int unsigned sent_bytes = 0;
  int unsigned stall_hold = 0;
  bit          calm = 1'b0;

  always #5 clk = ~clk;

  stomp_frame_deframer #(.LENGTH_BITS(LENGTH_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_byte(out_data_byte),
    .out_byte_kind(out_byte_kind), .out_end_mark(out_end_mark),
    .out_error_code(out_error_code), .out_body_length(out_body_length)
  );

  sfd_tag_checker #(.LENGTH_BITS(LENGTH_BITS)) tag_chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_data_byte(out_data_byte),
    .out_byte_kind(out_byte_kind), .out_end_mark(out_end_mark),
    .out_error_code(out_error_code), .out_body_length(out_body_length),
    .fail_count(fail_count), .waiting_count(waiting_count)
  );

  // Mostly short idle stretches, now and then a long one.
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 99) < 85)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_hold <= $urandom_range(0, 6);
    end else if ($urandom_range(0, 99) < 30) begin
      out_stall  <= 1'b1;
      stall_hold <= idle_len() - 1;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    int unsigned gap;
    gap = (calm || $urandom_range(0, 99) < 65) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  task automatic flush_stream();
    while (stream.size() != 0) push_byte(stream.pop_front());
  endtask

  // Holds the sender back until every expected result has come out.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (waiting_count != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic void add_byte(input logic [7:0] b);
    stream.insert(stream.size(), b);
  endfunction

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_line(input string s);
    add_str(s);
    add_byte(CH_LF);
  endfunction

  function automatic string bad_len_text(input int unsigned sel);
    case (sel)
      0:       return "+5";
      1:       return "-1";
      2:       return " 5";
      3:       return "";
      4:       return "2147483648";
      5:       return "99999999999";
      6:       return "1a";
      default: return "0x1";
    endcase
  endfunction

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 4))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      3:       return CH_CR;
      default: return CH_FF;
    endcase
  endfunction

  // A byte that may stand inside a line; key bytes also avoid the colon.
  function automatic logic [7:0] text_char(input bit key_side);
    logic [7:0] r;
    r = CH_LF;
    while (r == CH_LF || (key_side && r == CH_COLON)) begin
      if ($urandom_range(0, 3) == 0)
        r = 8'($urandom_range(0, 255));
      else
        r = 8'($urandom_range(33, 126));
    end
    return r;
  endfunction

  function automatic void add_text(input int unsigned n, input bit key_side);
    repeat (n) add_byte(text_char(key_side));
  endfunction

  function automatic void directed_frames();
    // Skipped whitespace, then a counted body holding NUL, LF and 0xFF.
    add_byte(CH_SPACE); add_byte(CH_TAB); add_byte(CH_LF); add_byte(CH_CR); add_byte(CH_FF);
    add_line("SEND");
    add_line("content-length:3");
    add_byte(CH_LF);
    add_byte(CH_NUL); add_byte(8'hFF); add_byte(CH_LF);
    add_byte(CH_NUL);
    // NUL inside the command, a colon in a value, a colonless line, NUL-ended body.
    add_byte(8'h43); add_byte(CH_NUL); add_byte(8'hFF); add_byte(CH_LF);
    add_line("a:b:c");
    add_line("junk");
    add_byte(CH_CR); add_byte(CH_LF);
    add_byte(CH_LF);
    add_str("hi");
    add_byte(CH_NUL);
    // Largest length, overridden by a later one; the counted body lacks its NUL.
    add_line("M");
    add_line("content-length:2147483647");
    add_line("content-length:2");
    add_byte(CH_LF);
    add_str("abZ");
    // Every kind of malformed length value drops its frame.
    for (int unsigned sel = 0; sel < 8; sel++) begin
      add_line("B");
      add_line({"content-length:", bad_len_text(sel)});
      add_byte(CH_LF);
    end
    add_line("B");
    add_str("content-length:1");
    add_byte(CH_CR); add_byte(CH_LF);
    add_byte(CH_LF);
    // A bad value followed by a good one, a zero length and keys that nearly match.
    add_line("G");
    add_line("content-length:-");
    add_line("content-length:1");
    add_byte(CH_LF);
    add_str("x");
    add_byte(CH_NUL);
    add_line("Z");
    add_line("content-length:9");
    add_line("content-length:0");
    add_line("content-lengthx:5");
    add_line("Content-Length:5");
    add_line("content-lengt:5");
    add_byte(CH_LF);
    add_str("q");
    add_byte(CH_NUL);
  endfunction

  function automatic void build_frame();
    int unsigned     n_hdr;
    int unsigned     r;
    longint unsigned v;
    longint unsigned blen;
    bit              bad;
    blen = 0;
    bad  = 1'b0;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 4)) add_byte(pick_blank());
    add_byte(8'($urandom_range(33, 126)));
    add_text($urandom_range(0, 8), 1'b0);
    add_byte(CH_LF);
    n_hdr = $urandom_range(0, 4);
    repeat (n_hdr) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        r = $urandom_range(0, 99);
        if (r < 15)      v = 0;
        else if (r < 85) v = $urandom_range(1, 12);
        else             v = $urandom_range(13, 40);
        add_str("content-length:");
        if ($urandom_range(0, 5) == 0) add_str("00");
        add_line($sformatf("%0d", v));
        blen = v;
        bad  = 1'b0;
      end else if (r < 38) begin
        add_line({"content-length:", bad_len_text($urandom_range(0, 7))});
        bad = 1'b1;
      end else if (r < 45) begin
        case ($urandom_range(0, 3))
          0:       add_str("content-lengt");
          1:       add_str("content-lengthx");
          2:       add_str("Content-Length");
          default: add_str("content-length ");
        endcase
        add_line(":7");
      end else if (r < 52) begin
        add_text($urandom_range(1, 8), 1'b1);
        add_byte(CH_LF);
      end else begin
        add_text($urandom_range(1, 8), 1'b1);
        add_byte(CH_COLON);
        add_text($urandom_range(0, 8), 1'b0);
        add_byte(CH_LF);
      end
    end
    add_byte(CH_LF);
    if (!bad && blen != 0) begin
      repeat (blen) add_byte(8'($urandom_range(0, 255)));
      add_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : CH_NUL);
    end else if (!bad) begin
      repeat ($urandom_range(0, 10)) add_byte(8'($urandom_range(1, 255)));
      add_byte(CH_NUL);
    end
    // Now and then cut the frame short.
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 6)) if (stream.size() > 1) void'(stream.pop_back());
  endfunction

  // Random bytes leaning toward the delimiters that move the parser around.
  function automatic void add_noise();
    repeat ($urandom_range(5, 30)) begin
      case ($urandom_range(0, 9))
        0:       add_byte(CH_LF);
        1:       add_byte(CH_COLON);
        2:       add_byte(CH_NUL);
        3:       add_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        default: add_byte(8'($urandom_range(0, 255)));
      endcase
    end
  endfunction

  initial begin
    int unsigned frames;
    frames = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    directed_frames();
    flush_stream();
    drain();

    while (sent_bytes < RANDOM_BYTES) begin
      calm <= ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) == 0)
        add_noise();
      else
        build_frame();
      flush_stream();
      frames++;
      if (frames % 8 == 0)
        drain();
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && waiting_count == 0)
      $display("** stomp_frame_deframer: PASSED **");
    else
      $display("** stomp_frame_deframer: FAILED **");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** stomp_frame_deframer: FAILED **");
    $finish;
  end

endmodule
